// ===== rtl/mate_read_allele_merge_top_defines.svh =====
// Assertion macros shared by the mate read allele merge checkers.
// Needs nothing else; included by the checker file only.
`ifndef MATE_READ_ALLELE_MERGE_TOP_DEFINES_SVH
`define MATE_READ_ALLELE_MERGE_TOP_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define MRAM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mram check failed");

// Condition holds in the cycle after the trigger.
`define MRAM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mram check failed");

`endif

// ===== rtl/mram_pkg.sv =====
// Types and constants of the mate read allele merge block.
// No dependencies; imported by every module of the block.
`default_nettype none

package mram_pkg;

   localparam int VARIANT_ID_WIDTH   = 24;
   localparam int MERGED_COUNT_WIDTH = 7;
   // wide enough for the largest supported list size
   localparam int JOB_COUNT_BITS     = 6;
   // calls a merged list needs to pass outside single read mode
   localparam int MIN_PAIR_CALLS     = 2;

   typedef struct packed {
      logic                        from_second_read;
      logic [VARIANT_ID_WIDTH-1:0] variant_id;
      logic [7:0]                  allele_code;
      logic [7:0]                  quality;
      logic                        is_breakend;
      logic                        end_of_pair;
   } mram_req_type;

   typedef struct packed {
      logic [VARIANT_ID_WIDTH-1:0]   out_variant_id;
      logic [7:0]                    out_allele_code;
      logic [7:0]                    out_quality;
      logic                          out_breakend;
      logic                          accepted;
      logic [MERGED_COUNT_WIDTH-1:0] merged_count;
      logic                          last;
   } mram_rsp_type;

   // stored call without its id
   typedef struct packed {
      logic [7:0] allele_code;
      logic [7:0] quality;
      logic       is_breakend;
   } mram_call_type;

   // one closed pair waiting for the merge engine
   typedef struct packed {
      logic                      bank;
      logic [JOB_COUNT_BITS-1:0] first_count;
      logic [JOB_COUNT_BITS-1:0] second_count;
   } mram_job_type;

   typedef struct packed {
      logic en;
      logic second;
   } mram_wr_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } mram_qstat_type;

endpackage

`default_nettype wire

// ===== rtl/mram_queue.sv =====
// Two-entry job queue between the loader and the merge engine.
// Depends on mram_pkg.
`default_nettype none

module mram_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  mram_pkg::mram_job_type  push_job,
   input  logic                    pop,
   output mram_pkg::mram_qstat_type status,
   output mram_pkg::mram_job_type  head_job
);
   import mram_pkg::*;

   mram_job_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = 2'(fill_ff + {1'b0, push} - {1'b0, pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign status.full      = fill_ff[1];
   assign status.not_empty = (fill_ff != 2'd0);
   assign head_job         = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/mram_front.sv =====
// Loader: takes calls, sorts them into the two read lists of the open bank,
// drops calls to a full list and closes the pair into a job. Uses mram_pkg.
`default_nettype none

module mram_front #(
   parameter int MAX_CALLS_PER_READ = 32,
   parameter int VARIANT_ID_BITS    = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  mram_pkg::mram_req_type req_data,
   output logic                  req_stall,
   input  logic                  q_full,
   output mram_pkg::mram_wr_type wr,
   output logic [$clog2(MAX_CALLS_PER_READ):0] wr_addr,
   output logic [((VARIANT_ID_BITS < mram_pkg::VARIANT_ID_WIDTH) ?
                  VARIANT_ID_BITS : mram_pkg::VARIANT_ID_WIDTH)-1:0] wr_id,
   output mram_pkg::mram_call_type wr_call,
   output logic                  push,
   output mram_pkg::mram_job_type push_job
);
   import mram_pkg::*;

   localparam int IdxW = $clog2(MAX_CALLS_PER_READ);
   localparam int CntW = $clog2(MAX_CALLS_PER_READ + 1);
   localparam int IdW  = (VARIANT_ID_BITS < VARIANT_ID_WIDTH) ?
                         VARIANT_ID_BITS : VARIANT_ID_WIDTH;

   logic [CntW-1:0] cnt_a_ff, cnt_a_in;
   logic [CntW-1:0] cnt_b_ff, cnt_b_in;
   logic            bank_ff, bank_in;
   logic            accept, to_second, room, store, close_pair;
   logic [CntW-1:0] cur_cnt, cnt_a_stored, cnt_b_stored;

   always_comb begin
      accept     = req_valid && !q_full;
      to_second  = req_data.from_second_read;
      cur_cnt    = to_second ? cnt_b_ff : cnt_a_ff;
      room       = (cur_cnt < CntW'(MAX_CALLS_PER_READ));
      store      = accept && room;
      close_pair = accept && req_data.end_of_pair;

      cnt_a_stored = cnt_a_ff + CntW'(store && !to_second);
      cnt_b_stored = cnt_b_ff + CntW'(store && to_second);

      cnt_a_in = close_pair ? '0 : cnt_a_stored;
      cnt_b_in = close_pair ? '0 : cnt_b_stored;
      bank_in  = bank_ff ^ close_pair;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_a_ff <= '0;
         cnt_b_ff <= '0;
         bank_ff  <= 1'b0;
      end else begin
         cnt_a_ff <= cnt_a_in;
         cnt_b_ff <= cnt_b_in;
         bank_ff  <= bank_in;
      end
   end

   assign req_stall = q_full;

   assign wr.en               = store;
   assign wr.second           = to_second;
   assign wr_addr             = {bank_ff, cur_cnt[IdxW-1:0]};
   assign wr_id               = req_data.variant_id[IdW-1:0];
   assign wr_call.allele_code = req_data.allele_code;
   assign wr_call.quality     = req_data.quality;
   assign wr_call.is_breakend = req_data.is_breakend;

   assign push                  = close_pair;
   assign push_job.bank         = bank_ff;
   assign push_job.first_count  = JOB_COUNT_BITS'(cnt_a_stored);
   assign push_job.second_count = JOB_COUNT_BITS'(cnt_b_stored);

endmodule

`default_nettype wire

// ===== rtl/mram_back.sv =====
// Merge engine: holds the two banked read lists, runs a counting pass and an
// emitting pass of the two-pointer merge, drives the result register. Uses mram_pkg.
`default_nettype none

module mram_back #(
   parameter int MAX_CALLS_PER_READ = 32,
   parameter int VARIANT_ID_BITS    = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    single_reads_mode,
   input  mram_pkg::mram_wr_type   wr,
   input  logic [$clog2(MAX_CALLS_PER_READ):0] wr_addr,
   input  logic [((VARIANT_ID_BITS < mram_pkg::VARIANT_ID_WIDTH) ?
                  VARIANT_ID_BITS : mram_pkg::VARIANT_ID_WIDTH)-1:0] wr_id,
   input  mram_pkg::mram_call_type wr_call,
   input  mram_pkg::mram_qstat_type qstat,
   input  mram_pkg::mram_job_type  head_job,
   output logic                    pop,
   input  logic                    rsp_stall,
   output logic                    rsp_valid,
   output mram_pkg::mram_rsp_type  rsp_data
);
   import mram_pkg::*;

   localparam int IdxW  = $clog2(MAX_CALLS_PER_READ);
   localparam int CntW  = $clog2(MAX_CALLS_PER_READ + 1);
   localparam int AddrW = IdxW + 1;
   localparam int Depth = 2 ** AddrW;
   localparam int IdW   = (VARIANT_ID_BITS < VARIANT_ID_WIDTH) ?
                          VARIANT_ID_BITS : VARIANT_ID_WIDTH;
   localparam int CallW = $bits(mram_call_type);
   localparam int EntW  = IdW + CallW;
   localparam int NW    = $clog2(2 * MAX_CALLS_PER_READ + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_COUNT  = 2'd1;
   localparam logic [1:0] ST_EMIT   = 2'd2;
   localparam logic [1:0] ST_REJECT = 2'd3;

   logic [EntW-1:0] mem_a_ff [Depth];
   logic [EntW-1:0] mem_b_ff [Depth];
   logic [EntW-1:0] rd_a_ff, rd_b_ff;

   logic [1:0]      state_ff, state_in;
   logic [CntW-1:0] ptr_a_ff, ptr_a_in, ptr_b_ff, ptr_b_in;
   logic [NW-1:0]   n_ff, n_in, k_ff, k_in;
   logic            rsp_valid_ff, rsp_valid_in;
   mram_rsp_type    rsp_ff, rsp_in;

   logic [CntW-1:0] cnt_a, cnt_b;
   logic [AddrW-1:0] rd_addr_a, rd_addr_b;
   logic [IdW-1:0]  id_a, id_b, sel_id;
   mram_call_type   call_a, call_b, sel_call;
   logic            a_more, b_more, take_a, take_b, both, keep, produce, done;
   logic            step_a, step_b, out_free, pass, load;

   // decode the registered read data
   always_comb begin
      cnt_a  = CntW'(head_job.first_count);
      cnt_b  = CntW'(head_job.second_count);
      id_a   = rd_a_ff[EntW-1:CallW];
      id_b   = rd_b_ff[EntW-1:CallW];
      call_a = mram_call_type'(rd_a_ff[CallW-1:0]);
      call_b = mram_call_type'(rd_b_ff[CallW-1:0]);

      a_more  = (ptr_a_ff < cnt_a);
      b_more  = (ptr_b_ff < cnt_b);
      take_a  = a_more && (!b_more || (id_a < id_b));
      take_b  = b_more && (!a_more || (id_a > id_b));
      both    = a_more && b_more && (id_a == id_b);
      keep    = both && (call_a.allele_code == call_b.allele_code);
      produce = take_a || take_b || keep;
      done    = !a_more && !b_more;
      step_a  = take_a || both;
      step_b  = take_b || both;

      if (take_a) begin
         sel_id   = id_a;
         sel_call = call_a;
      end else if (take_b) begin
         sel_id   = id_b;
         sel_call = call_b;
      end else begin
         // shared id, same allele: best quality, breakend of second read
         sel_id               = id_a;
         sel_call.allele_code = call_a.allele_code;
         sel_call.quality     = (call_b.quality > call_a.quality) ?
                                call_b.quality : call_a.quality;
         sel_call.is_breakend = call_b.is_breakend;
      end

      out_free = !rsp_valid_ff || !rsp_stall;
      pass     = (n_ff >= NW'(MIN_PAIR_CALLS)) ||
                 (single_reads_mode && (n_ff != '0));
   end

   always_comb begin
      state_in = state_ff;
      ptr_a_in = ptr_a_ff;
      ptr_b_in = ptr_b_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      pop      = 1'b0;
      load     = 1'b0;

      rsp_in.out_variant_id  = VARIANT_ID_WIDTH'(sel_id);
      rsp_in.out_allele_code = sel_call.allele_code;
      rsp_in.out_quality     = sel_call.quality;
      rsp_in.out_breakend    = sel_call.is_breakend;
      rsp_in.accepted        = 1'b1;
      rsp_in.merged_count    = MERGED_COUNT_WIDTH'(n_ff);
      rsp_in.last            = (NW'(k_ff + 1'b1) == n_ff);

      case (state_ff)
         ST_IDLE: begin
            if (qstat.not_empty) begin
               ptr_a_in = '0;
               ptr_b_in = '0;
               n_in     = '0;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            if (done) begin
               ptr_a_in = '0;
               ptr_b_in = '0;
               k_in     = '0;
               state_in = pass ? ST_EMIT : ST_REJECT;
            end else begin
               ptr_a_in = ptr_a_ff + CntW'(step_a);
               ptr_b_in = ptr_b_ff + CntW'(step_b);
               n_in     = n_ff + NW'(produce);
            end
         end
         ST_EMIT: begin
            if (done) begin
               pop      = 1'b1;
               state_in = ST_IDLE;
            end else if (!produce || out_free) begin
               ptr_a_in = ptr_a_ff + CntW'(step_a);
               ptr_b_in = ptr_b_ff + CntW'(step_b);
               if (produce) begin
                  load = 1'b1;
                  k_in = k_ff + 1'b1;
               end
            end
         end
         ST_REJECT: begin
            rsp_in              = '0;
            rsp_in.merged_count = MERGED_COUNT_WIDTH'(n_ff);
            rsp_in.last         = 1'b1;
            if (out_free) begin
               load     = 1'b1;
               pop      = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
      rd_addr_a    = {head_job.bank, ptr_a_in[IdxW-1:0]};
      rd_addr_b    = {head_job.bank, ptr_b_in[IdxW-1:0]};
   end

   // list memories: loader writes the open bank, engine reads the closed one
   always_ff @(posedge clock) begin
      if (wr.en && !wr.second) begin
         mem_a_ff[wr_addr] <= {wr_id, wr_call};
      end
      rd_a_ff <= mem_a_ff[rd_addr_a];
   end

   always_ff @(posedge clock) begin
      if (wr.en && wr.second) begin
         mem_b_ff[wr_addr] <= {wr_id, wr_call};
      end
      rd_b_ff <= mem_b_ff[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/mate_read_allele_merge_top.sv =====
// Each pair is merged in c merge steps (calls of both reads, shared ids counted once).
// Loading takes one call per cycle while the job queue is not full; the merge engine
// then runs a counting pass of c steps and, unless the pair is rejected, an emitting
// pass of one merge step per cycle while the result channel is not stalled,
// overlapped with loading of the next pair through two list banks and a two-entry
// job queue.
// Reset (synchronous, active high) empties lists, queue and result register, mode 0.
`default_nettype none

module mate_read_allele_merge_top #(
   parameter int MAX_CALLS_PER_READ = 32,
   parameter int VARIANT_ID_BITS    = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   // call input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  mram_pkg::mram_req_type req_data,
   // merged results
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output mram_pkg::mram_rsp_type rsp_data,
   // mode register write
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);
   import mram_pkg::*;

   localparam int AddrW = $clog2(MAX_CALLS_PER_READ) + 1;
   localparam int IdW   = (VARIANT_ID_BITS < VARIANT_ID_WIDTH) ?
                          VARIANT_ID_BITS : VARIANT_ID_WIDTH;

   // single_reads_mode register; the write port never pushes back
   logic mode_ff, mode_in;

   assign csr_ready = 1'b1;
   assign mode_in   = csr_valid ? csr_wdata : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // loader to list memories
   mram_wr_type     wr;
   logic [AddrW-1:0] wr_addr;
   logic [IdW-1:0]  wr_id;
   mram_call_type   wr_call;

   // job queue between loader and merge engine
   logic            push, pop;
   mram_job_type    push_job, head_job;
   mram_qstat_type  qstat;

   // Front: each call transfer lands in the open bank of its read's list.
   // A call to a full list is dropped; end_of_pair still closes the pair,
   // flips the bank and queues a job. Stalls only when both banks await merge.
   mram_front #(
      .MAX_CALLS_PER_READ (MAX_CALLS_PER_READ),
      .VARIANT_ID_BITS    (VARIANT_ID_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .q_full    (qstat.full),
      .wr        (wr),
      .wr_addr   (wr_addr),
      .wr_id     (wr_id),
      .wr_call   (wr_call),
      .push      (push),
      .push_job  (push_job)
   );

   mram_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .status   (qstat),
      .head_job (head_job)
   );

   // Back: first pass counts the merged list so every result can carry the
   // count; second pass walks the same merge and emits, or one reject goes out.
   // The job is retired (bank freed) once its last result is loaded.
   mram_back #(
      .MAX_CALLS_PER_READ (MAX_CALLS_PER_READ),
      .VARIANT_ID_BITS    (VARIANT_ID_BITS)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .single_reads_mode (mode_ff),
      .wr                (wr),
      .wr_addr           (wr_addr),
      .wr_id             (wr_id),
      .wr_call           (wr_call),
      .qstat             (qstat),
      .head_job          (head_job),
      .pop               (pop),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data)
   );

endmodule

`default_nettype wire

// ===== rtl/mram_checker.sv =====
// Port-level checks on the result channel of the allele merge block.
// Depends on mram_pkg and the assertion macro header; bound to the top level.
`default_nettype none
`include "mate_read_allele_merge_top_defines.svh"

module mram_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input mram_pkg::mram_rsp_type rsp_data
);
   import mram_pkg::*;

   `MRAM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data))

   // a reject is a lone, empty result with a short list
   `MRAM_ASSERT_IMPLY(a_reject_shape, clock, reset, rsp_valid && !rsp_data.accepted, rsp_data.last && (rsp_data.out_variant_id == '0) && (rsp_data.out_quality == '0) && (rsp_data.merged_count < MERGED_COUNT_WIDTH'(MIN_PAIR_CALLS)))

   `MRAM_ASSERT_IMPLY(a_accept_count, clock, reset, rsp_valid && rsp_data.accepted, rsp_data.merged_count != '0)

   `MRAM_ASSERT_IMPLY(a_single_last, clock, reset, rsp_valid && rsp_data.accepted && (rsp_data.merged_count == MERGED_COUNT_WIDTH'(1)), rsp_data.last)

endmodule

bind mate_read_allele_merge_top mram_checker u_mram_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
